// ----- rtl/core/ipa_pkg.sv -----
// Shared types, constants and helpers for the refcounted ID pool allocator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ipa_pkg;

    localparam int POOL_SIZE = 1024;
    localparam int ID_W      = 16;
    localparam int CNT_W     = 11;
    localparam int ENTRY_W   = 8;
    localparam int OFF_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int PTR_W     = $clog2(POOL_SIZE + 1);
    localparam int IDX_W     = (CNT_W > PTR_W) ? CNT_W : PTR_W;

    localparam logic [ENTRY_W-1:0] ENTRY_FREE     = 8'd0;
    localparam logic [ENTRY_W-1:0] ENTRY_FIRST    = 8'd1;
    localparam logic [ENTRY_W-1:0] ENTRY_MAX      = 8'd254;
    localparam logic [ENTRY_W-1:0] ENTRY_RESERVED = 8'd255;

    typedef enum logic [1:0] {
        FUNC_RESERVE   = 2'd0,
        FUNC_UNRESERVE = 2'd1,
        FUNC_ASSIGN    = 2'd2,
        FUNC_QUERY     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_OUTSIDE   = 2'd2,
        ST_WRONG     = 2'd3
    } status_t;

    typedef struct packed {
        func_t                  func;
        logic signed [ID_W-1:0] id;
        logic signed [ID_W-1:0] old_id;
        logic [CNT_W-1:0]       count;
    } req_t;

    typedef struct packed {
        logic signed [ID_W-1:0] result_id;
        logic [ENTRY_W-1:0]     ref_count;
        status_t                status;
    } res_t;

    typedef struct packed {
        logic               wr_en;
        logic [OFF_W-1:0]   wr_addr;
        logic [ENTRY_W-1:0] wr_data;
        logic               rd_en;
        logic [OFF_W-1:0]   rd_addr;
    } mem_cmd_t;

    function automatic logic in_pool(input logic [ID_W-1:0] off);
        return 32'(off) < POOL_SIZE;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ipa_ram.sv -----
// Usage table storage: one write port, one read port, registered read data.
// Depends on ipa_pkg for depth and entry width.
`default_nettype none

module ipa_ram (
    input  wire logic                        aclk,
    input  wire logic                        wr_en,
    input  wire logic [ipa_pkg::OFF_W-1:0]   wr_addr,
    input  wire logic [ipa_pkg::ENTRY_W-1:0] wr_data,
    input  wire logic                        rd_en,
    input  wire logic [ipa_pkg::OFF_W-1:0]   rd_addr,
    output logic      [ipa_pkg::ENTRY_W-1:0] rd_data
);
    import ipa_pkg::*;

    logic [ENTRY_W-1:0] mem [POOL_SIZE];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ipa_engine.sv -----
// Request sequencer: walks the usage table through the RAM port, one entry
// per cycle, with a one-deep read pipeline. Depends on ipa_pkg.
`default_nettype none

module ipa_engine (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [ipa_pkg::ID_W-1:0]    lowest_id,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire ipa_pkg::req_t               req,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output ipa_pkg::res_t                    res,
    output ipa_pkg::mem_cmd_t                mem_cmd,
    input  wire logic [ipa_pkg::ENTRY_W-1:0] rd_data
);
    import ipa_pkg::*;

    typedef enum logic [11:0] {
        S_CLEAR       = 12'b0000_0000_0001,
        S_IDLE        = 12'b0000_0000_0010,
        S_RSV_BUMP    = 12'b0000_0000_0100,
        S_SCAN        = 12'b0000_0000_1000,
        S_FILL        = 12'b0000_0001_0000,
        S_UNRSV       = 12'b0000_0010_0000,
        S_ASG_OLD     = 12'b0000_0100_0000,
        S_ASG_OLD_CHK = 12'b0000_1000_0000,
        S_ASG_NEW     = 12'b0001_0000_0000,
        S_ASG_NEW_CHK = 12'b0010_0000_0000,
        S_QUERY       = 12'b0100_0000_0000,
        S_DONE        = 12'b1000_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [ID_W-1:0]    old_id_reg, old_id_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   run_reg, run_next;
    logic               pend_reg, pend_next;
    logic [OFF_W-1:0]   pend_addr_reg, pend_addr_next;
    logic [PTR_W-1:0]   bump_reg, bump_next;
    logic [OFF_W-1:0]   fill_addr_reg, fill_addr_next;
    logic [OFF_W-1:0]   fill_end_reg, fill_end_next;
    logic               outside_reg, outside_next;
    logic               wrong_reg, wrong_next;
    res_t               res_reg, res_next;

    logic [ID_W-1:0]    q_off, old_off, new_off, walk_off;
    logic [OFF_W-1:0]   bump_addr, scan_start;
    logic [CNT_W-1:0]   run_inc;
    logic               issue_more, scan_more, bump_fits, new_flag;

    assign q_off      = ID_W'(req.id) - lowest_id;
    assign old_off    = old_id_reg - lowest_id;
    assign new_off    = id_reg - lowest_id;
    assign walk_off   = id_reg + ID_W'(idx_reg) - lowest_id;
    assign bump_addr  = OFF_W'(bump_reg) + OFF_W'(idx_reg);
    assign issue_more = idx_reg < IDX_W'(count_reg);
    assign scan_more  = idx_reg < IDX_W'(POOL_SIZE);
    assign run_inc    = run_reg + CNT_W'(1);
    assign scan_start = pend_addr_reg - OFF_W'(count_reg - CNT_W'(1));
    assign bump_fits  = ({1'b0, IDX_W'(bump_reg)} + {1'b0, IDX_W'(req.count)})
                        <= (IDX_W+1)'(POOL_SIZE);
    assign new_flag   = (rd_data == ENTRY_MAX) || (rd_data == ENTRY_FREE);

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb begin
        state_next     = state_reg;
        id_next        = id_reg;
        old_id_next    = old_id_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        run_next       = run_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        bump_next      = bump_reg;
        fill_addr_next = fill_addr_reg;
        fill_end_next  = fill_end_reg;
        outside_next   = outside_reg;
        wrong_next     = wrong_reg;
        res_next       = res_reg;
        mem_cmd        = '0;

        unique case (state_reg)
            S_CLEAR: begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = OFF_W'(idx_reg);
                mem_cmd.wr_data = ENTRY_FREE;
                if (idx_reg == IDX_W'(POOL_SIZE - 1)) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_IDLE: begin
                if (req_valid) begin
                    id_next      = ID_W'(req.id);
                    old_id_next  = ID_W'(req.old_id);
                    count_next   = req.count;
                    idx_next     = '0;
                    run_next     = '0;
                    pend_next    = 1'b0;
                    outside_next = 1'b0;
                    wrong_next   = 1'b0;
                    res_next     = '0;
                    unique case (req.func)
                        FUNC_RESERVE: begin
                            if (req.count == '0) begin
                                res_next.status = ST_OUTSIDE;
                                state_next      = S_DONE;
                            end else if (bump_fits) begin
                                res_next.result_id = lowest_id + ID_W'(bump_reg);
                                state_next         = S_RSV_BUMP;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        FUNC_UNRESERVE: begin
                            if (req.count == '0) begin
                                res_next.status = ST_OUTSIDE;
                                state_next      = S_DONE;
                            end else begin
                                state_next = S_UNRSV;
                            end
                        end
                        FUNC_ASSIGN: begin
                            state_next = (req.id == req.old_id) ? S_DONE : S_ASG_OLD;
                        end
                        FUNC_QUERY: begin
                            if (in_pool(q_off)) begin
                                mem_cmd.rd_en   = 1'b1;
                                mem_cmd.rd_addr = q_off[OFF_W-1:0];
                                state_next      = S_QUERY;
                            end else begin
                                res_next.status = ST_OUTSIDE;
                                state_next      = S_DONE;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end

            S_RSV_BUMP: begin
                if (pend_reg) begin
                    if (rd_data == ENTRY_FREE) begin
                        mem_cmd.wr_en   = 1'b1;
                        mem_cmd.wr_addr = pend_addr_reg;
                        mem_cmd.wr_data = ENTRY_RESERVED;
                    end else begin
                        wrong_next = 1'b1;
                    end
                end
                if (issue_more) begin
                    mem_cmd.rd_en   = 1'b1;
                    mem_cmd.rd_addr = bump_addr;
                    pend_next       = 1'b1;
                    pend_addr_next  = bump_addr;
                    idx_next        = idx_reg + IDX_W'(1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        bump_next       = bump_reg + PTR_W'(count_reg);
                        res_next.status = wrong_reg ? ST_WRONG : ST_OK;
                        state_next      = S_DONE;
                    end
                end
            end

            S_SCAN: begin
                if (pend_reg && (rd_data == ENTRY_FREE) && (run_inc == count_reg)) begin
                    // run complete: stop reading and fill it
                    pend_next          = 1'b0;
                    fill_addr_next     = scan_start;
                    fill_end_next      = pend_addr_reg;
                    res_next.result_id = lowest_id + ID_W'(scan_start);
                    if (PTR_W'(pend_addr_reg) >= bump_reg) begin
                        bump_next = PTR_W'(pend_addr_reg) + PTR_W'(1);
                    end
                    state_next = S_FILL;
                end else begin
                    if (pend_reg) begin
                        run_next = (rd_data == ENTRY_FREE) ? run_inc : '0;
                    end
                    if (scan_more) begin
                        mem_cmd.rd_en   = 1'b1;
                        mem_cmd.rd_addr = OFF_W'(idx_reg);
                        pend_next       = 1'b1;
                        pend_addr_next  = OFF_W'(idx_reg);
                        idx_next        = idx_reg + IDX_W'(1);
                    end else begin
                        pend_next = 1'b0;
                        if (!pend_reg) begin
                            res_next.status    = ST_EXHAUSTED;
                            res_next.result_id = '0;
                            state_next         = S_DONE;
                        end
                    end
                end
            end

            S_FILL: begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = fill_addr_reg;
                mem_cmd.wr_data = ENTRY_RESERVED;
                if (fill_addr_reg == fill_end_reg) begin
                    res_next.status = ST_OK;
                    state_next      = S_DONE;
                end else begin
                    fill_addr_next = fill_addr_reg + OFF_W'(1);
                end
            end

            S_UNRSV: begin
                if (pend_reg) begin
                    if (rd_data == ENTRY_RESERVED) begin
                        mem_cmd.wr_en   = 1'b1;
                        mem_cmd.wr_addr = pend_addr_reg;
                        mem_cmd.wr_data = ENTRY_FREE;
                    end else begin
                        wrong_next = 1'b1;
                    end
                end
                if (issue_more) begin
                    idx_next = idx_reg + IDX_W'(1);
                    if (in_pool(walk_off)) begin
                        mem_cmd.rd_en   = 1'b1;
                        mem_cmd.rd_addr = walk_off[OFF_W-1:0];
                        pend_next       = 1'b1;
                        pend_addr_next  = walk_off[OFF_W-1:0];
                    end else begin
                        outside_next = 1'b1;
                        pend_next    = 1'b0;
                    end
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        res_next.status = outside_reg ? ST_OUTSIDE :
                                          (wrong_reg ? ST_WRONG : ST_OK);
                        state_next      = S_DONE;
                    end
                end
            end

            S_ASG_OLD: begin
                if (in_pool(old_off)) begin
                    mem_cmd.rd_en   = 1'b1;
                    mem_cmd.rd_addr = old_off[OFF_W-1:0];
                    pend_addr_next  = old_off[OFF_W-1:0];
                    state_next      = S_ASG_OLD_CHK;
                end else begin
                    state_next = S_ASG_NEW;
                end
            end

            S_ASG_OLD_CHK: begin
                mem_cmd.wr_addr = pend_addr_reg;
                if (rd_data == ENTRY_FREE) begin
                    wrong_next = 1'b1;
                end else if (rd_data == ENTRY_RESERVED) begin
                    wrong_next      = 1'b1;
                    mem_cmd.wr_en   = 1'b1;
                    mem_cmd.wr_data = ENTRY_FREE;
                end else begin
                    mem_cmd.wr_en   = 1'b1;
                    mem_cmd.wr_data = rd_data - ENTRY_FIRST;
                end
                state_next = S_ASG_NEW;
            end

            S_ASG_NEW: begin
                if (in_pool(new_off)) begin
                    mem_cmd.rd_en   = 1'b1;
                    mem_cmd.rd_addr = new_off[OFF_W-1:0];
                    pend_addr_next  = new_off[OFF_W-1:0];
                    state_next      = S_ASG_NEW_CHK;
                end else begin
                    res_next.status = wrong_reg ? ST_WRONG : ST_OK;
                    state_next      = S_DONE;
                end
            end

            S_ASG_NEW_CHK: begin
                mem_cmd.wr_addr = pend_addr_reg;
                if (!new_flag) begin
                    mem_cmd.wr_en   = 1'b1;
                    mem_cmd.wr_data = (rd_data == ENTRY_RESERVED) ? ENTRY_FIRST :
                                      rd_data + ENTRY_FIRST;
                end
                res_next.status = (wrong_reg || new_flag) ? ST_WRONG : ST_OK;
                state_next      = S_DONE;
            end

            S_QUERY: begin
                res_next.ref_count = rd_data;
                res_next.status    = ST_OK;
                state_next         = S_DONE;
            end

            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            bump_reg  <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            bump_reg  <= bump_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg        <= id_next;
        old_id_reg    <= old_id_next;
        count_reg     <= count_next;
        run_reg       <= run_next;
        pend_addr_reg <= pend_addr_next;
        fill_addr_reg <= fill_addr_next;
        fill_end_reg  <= fill_end_next;
        outside_reg   <= outside_next;
        wrong_reg     <= wrong_next;
        res_reg       <= res_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/refcounted_id_pool_allocator_top.sv -----
// Top level of the refcounted ID pool allocator: config register, output
// register, usage table RAM and request sequencer. Depends on ipa_pkg,
// ipa_ram and ipa_engine.
//
//   channel   signals                                     direction
//   request   s_valid s_ready s_func s_id s_old_id s_count  in
//   result    m_valid m_ready m_result_id m_ref_count m_status out
//   config    cfg_wr_en cfg_wr_data (lowest_id)             in
//
// Reset starts a clearing pass over all POOL_SIZE (1024) table entries;
// s_ready stays low until it ends, config writes are taken throughout.
// Requests are paced by the single RAM read port (one entry a cycle): a query
// reads one entry, assign reads at most the old and the new entry, reserve at
// the bump pointer and unreserve walk count entries, and reserve by scan may
// read the whole table and then writes the run. A stalled m_ready holds one result
// in the output register while the next request is worked on.
`default_nettype none

module refcounted_id_pool_allocator_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic signed [ipa_pkg::ID_W-1:0]  cfg_wr_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [1:0]                       s_func,
    input  wire logic signed [ipa_pkg::ID_W-1:0]  s_id,
    input  wire logic signed [ipa_pkg::ID_W-1:0]  s_old_id,
    input  wire logic [ipa_pkg::CNT_W-1:0]        s_count,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [ipa_pkg::ID_W-1:0]       m_result_id,
    output logic [ipa_pkg::ENTRY_W-1:0]           m_ref_count,
    output logic [1:0]                            m_status
);
    import ipa_pkg::*;

    logic [ID_W-1:0]    lowest_id_reg;
    logic               m_valid_reg;
    res_t               m_res_reg;
    req_t               req;
    res_t               res;
    logic               res_valid, res_ready;
    mem_cmd_t           mem_cmd;
    logic [ENTRY_W-1:0] rd_data;

    assign req.func   = func_t'(s_func);
    assign req.id     = s_id;
    assign req.old_id = s_old_id;
    assign req.count  = s_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lowest_id_reg <= '0;
        end else if (cfg_wr_en) begin
            lowest_id_reg <= ID_W'(cfg_wr_data);
        end
    end

    ipa_ram u_ram (
        .aclk    (aclk),
        .wr_en   (mem_cmd.wr_en),
        .wr_addr (mem_cmd.wr_addr),
        .wr_data (mem_cmd.wr_data),
        .rd_en   (mem_cmd.rd_en),
        .rd_addr (mem_cmd.rd_addr),
        .rd_data (rd_data)
    );

    ipa_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .lowest_id (lowest_id_reg),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_cmd   (mem_cmd),
        .rd_data   (rd_data)
    );

    // take a new result when the output register is empty or draining
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_result_id = m_res_reg.result_id;
    assign m_ref_count = m_res_reg.ref_count;
    assign m_status    = m_res_reg.status;

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res_ready |=> m_valid)
        else $error("finished result not moved into output register");

    a_exhausted_no_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_EXHAUSTED) |-> (m_result_id == '0))
        else $error("failed reserve returned a nonzero ID");

    a_count_only_query: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_ref_count != '0) |-> (m_status == ST_OK) && (m_result_id == '0))
        else $error("nonzero ref_count outside a successful query");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("sequencer ready again right after taking a request");

endmodule

`default_nettype wire

// ----- sim/tb_refcounted_id_pool_allocator_top.sv -----
// Self-checking testbench for refcounted_id_pool_allocator_top: a directed
// table, then randomized requests over several pool bases, checked against a
// behavioral model of the usage table. Depends on ipa_pkg and the block's RTL.
`default_nettype none

module tb_refcounted_id_pool_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ipa_pkg::*;

    // Slowest request is a full scan plus run; allow that for
    // every request with stalls and gaps, plus the clearing pass, several times.
    localparam int CYCLE_LIMIT  = 6_000_000;
    localparam int NUM_DIRECTED = 24;
    localparam int NUM_PHASES   = 5;
    localparam int PHASE_ITEMS  = 52;
    localparam int HOT_ITEMS    = 300;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_SLOW, RX_PERIODIC} rx_mode_t;

    typedef struct packed {
        func_t              f;
        logic [ID_W-1:0]    id;
        logic [ID_W-1:0]    old_id;
        logic [CNT_W-1:0]   cnt;
        logic               known;
        res_t               known_res;
    } dir_row_t;

    typedef struct {
        int unsigned off;
        int unsigned len;
    } held_run_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [ID_W-1:0]      cfg_wr_data = '0;
    logic                 s_valid     = 1'b0;
    wire logic            s_ready;
    logic [1:0]           s_func      = '0;
    logic [ID_W-1:0]      s_id        = '0;
    logic [ID_W-1:0]      s_old_id    = '0;
    logic [CNT_W-1:0]     s_count     = '0;
    wire logic            m_valid;
    logic                 m_ready     = 1'b0;
    wire logic [ID_W-1:0] m_result_id;
    wire logic [ENTRY_W-1:0] m_ref_count;
    wire logic [1:0]      m_status;

    // model state
    logic [ENTRY_W-1:0] usage_q [POOL_SIZE];
    int                 bump_q;
    logic [ID_W-1:0]    base_id;

    res_t      expected_results [$];
    held_run_t held_runs [$];
    int        mismatches = 0;
    int        cycle_cnt  = 0;
    int        burst_left = 0;

    rx_mode_t    rx_mode     = RX_ALWAYS;
    int          rx_left     = 0;
    logic [31:0] rx_tick     = '0;

    dir_row_t directed_rows [NUM_DIRECTED] = '{
        '{FUNC_QUERY,     16'h0000, 16'h0000, 11'd0,    1'b1, '{16'h0000, 8'd0,   ST_OK}},
        '{FUNC_QUERY,     16'h0400, 16'h0000, 11'd0,    1'b1, '{16'h0000, 8'd0,   ST_OUTSIDE}},
        '{FUNC_QUERY,     16'hFFFF, 16'h0000, 11'd0,    1'b1, '{16'h0000, 8'd0,   ST_OUTSIDE}},
        '{FUNC_RESERVE,   16'h0000, 16'h0000, 11'd0,    1'b1, '{16'h0000, 8'd0,   ST_OUTSIDE}},
        '{FUNC_UNRESERVE, 16'h0000, 16'h0000, 11'd0,    1'b1, '{16'h0000, 8'd0,   ST_OUTSIDE}},
        '{FUNC_RESERVE,   16'h0000, 16'h0000, 11'd1,    1'b1, '{16'h0000, 8'd0,   ST_OK}},
        '{FUNC_RESERVE,   16'h0000, 16'h0000, 11'd3,    1'b1, '{16'h0001, 8'd0,   ST_OK}},
        '{FUNC_QUERY,     16'h0000, 16'h0000, 11'd0,    1'b1, '{16'h0000, 8'd255, ST_OK}},
        '{FUNC_ASSIGN,    16'h0000, 16'h0000, 11'd0,    1'b1, '{16'h0000, 8'd0,   ST_OK}},
        '{FUNC_RESERVE,   16'h0000, 16'h0000, 11'd2047, 1'b1, '{16'h0000, 8'd0,   ST_EXHAUSTED}},
        '{FUNC_RESERVE,   16'h0000, 16'h0000, 11'd1024, 1'b0, '0},
        '{FUNC_ASSIGN,    16'h0001, 16'h8000, 11'd0,    1'b0, '0},
        '{FUNC_ASSIGN,    16'h0002, 16'h0001, 11'd0,    1'b0, '0},
        '{FUNC_ASSIGN,    16'h0001, 16'h0002, 11'd0,    1'b0, '0},
        '{FUNC_ASSIGN,    16'h0005, 16'h0003, 11'd0,    1'b0, '0},
        '{FUNC_QUERY,     16'h0002, 16'h0000, 11'd0,    1'b0, '0},
        '{FUNC_UNRESERVE, 16'h0000, 16'h0000, 11'd4,    1'b0, '0},
        '{FUNC_UNRESERVE, 16'hFFFE, 16'h0000, 11'd3,    1'b0, '0},
        '{FUNC_UNRESERVE, 16'h03FF, 16'h0000, 11'd2,    1'b0, '0},
        '{FUNC_RESERVE,   16'h0000, 16'h0000, 11'd2,    1'b0, '0},
        '{FUNC_QUERY,     16'h7FFF, 16'h0000, 11'd0,    1'b1, '{16'h0000, 8'd0,   ST_OUTSIDE}},
        '{FUNC_ASSIGN,    16'h0400, 16'h7FFF, 11'd0,    1'b1, '{16'h0000, 8'd0,   ST_OK}},
        '{FUNC_QUERY,     16'h8000, 16'h0000, 11'd0,    1'b1, '{16'h0000, 8'd0,   ST_OUTSIDE}},
        '{FUNC_ASSIGN,    16'h0004, 16'h0005, 11'd0,    1'b0, '0}
    };

    refcounted_id_pool_allocator_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_id        (s_id),
        .s_old_id    (s_old_id),
        .s_count     (s_count),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result_id (m_result_id),
        .m_ref_count (m_ref_count),
        .m_status    (m_status)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic res_t pool_predict(input func_t f, input logic [ID_W-1:0] idv,
                                          input logic [ID_W-1:0] oldv,
                                          input logic [CNT_W-1:0] cnt);
        res_t            r;
        int              run;
        int              hit;
        int              start;
        logic            outside;
        logic            wrong;
        logic [ID_W-1:0] off;
        logic [ENTRY_W-1:0] v;
        r = '0;
        r.status = ST_OK;
        case (f)
            FUNC_RESERVE: begin
                if (cnt == 0) begin
                    r.status = ST_OUTSIDE;
                end else if (bump_q + int'(cnt) <= POOL_SIZE) begin
                    for (int i = 0; i < int'(cnt); i++) begin
                        if (usage_q[bump_q + i] == ENTRY_FREE)
                            usage_q[bump_q + i] = ENTRY_RESERVED;
                        else
                            r.status = ST_WRONG;
                    end
                    r.result_id = base_id + ID_W'(bump_q);
                    bump_q += int'(cnt);
                end else begin
                    // first fit from the pool start
                    run = 0;
                    hit = -1;
                    for (int i = 0; i < POOL_SIZE; i++) begin
                        if (usage_q[i] == ENTRY_FREE) begin
                            run++;
                            if (run == int'(cnt)) begin
                                hit = i;
                                break;
                            end
                        end else begin
                            run = 0;
                        end
                    end
                    if (hit >= 0) begin
                        start = hit + 1 - int'(cnt);
                        if (hit >= bump_q)
                            bump_q = hit + 1;
                        for (int k = start; k <= hit; k++)
                            usage_q[k] = ENTRY_RESERVED;
                        r.result_id = base_id + ID_W'(start);
                    end else begin
                        r.status = ST_EXHAUSTED;
                    end
                end
            end
            FUNC_UNRESERVE: begin
                outside = (cnt == 0);
                wrong = 1'b0;
                for (int i = 0; i < int'(cnt); i++) begin
                    off = idv + ID_W'(i) - base_id;
                    if (int'(off) >= POOL_SIZE)
                        outside = 1'b1;
                    else if (usage_q[off] != ENTRY_RESERVED)
                        wrong = 1'b1;
                    else
                        usage_q[off] = ENTRY_FREE;
                end
                r.status = outside ? ST_OUTSIDE : (wrong ? ST_WRONG : ST_OK);
            end
            FUNC_ASSIGN: begin
                if (idv != oldv) begin
                    off = oldv - base_id;
                    if (int'(off) < POOL_SIZE) begin
                        v = usage_q[off];
                        if (v == ENTRY_FREE) begin
                            r.status = ST_WRONG;
                        end else if (v == ENTRY_RESERVED) begin
                            r.status = ST_WRONG;
                            usage_q[off] = ENTRY_FREE;
                        end else begin
                            usage_q[off] = v - 1'b1;
                        end
                    end
                    off = idv - base_id;
                    if (int'(off) < POOL_SIZE) begin
                        v = usage_q[off];
                        if (v == ENTRY_MAX || v == ENTRY_FREE)
                            r.status = ST_WRONG;
                        else if (v == ENTRY_RESERVED)
                            usage_q[off] = ENTRY_FIRST;
                        else
                            usage_q[off] = v + 1'b1;
                    end
                end
            end
            default: begin
                off = idv - base_id;
                if (int'(off) < POOL_SIZE)
                    r.ref_count = usage_q[off];
                else
                    r.status = ST_OUTSIDE;
            end
        endcase
        return r;
    endfunction

    // An ID inside some run this bench reserved, or anywhere in the pool.
    function automatic logic [ID_W-1:0] pick_held_id();
        int unsigned k;
        if (held_runs.size() == 0)
            return base_id + ID_W'($urandom_range(POOL_SIZE - 1));
        k = $urandom_range(held_runs.size() - 1);
        return base_id + ID_W'(held_runs[k].off + $urandom_range(held_runs[k].len - 1));
    endfunction

    // Present one request, wait for its acceptance, then predict its result.
    task automatic issue_request(input func_t f, input logic [ID_W-1:0] idv,
                                 input logic [ID_W-1:0] oldv, input logic [CNT_W-1:0] cnt,
                                 input logic known, input res_t known_res,
                                 output res_t predicted);
        int gap;
        held_run_t hr;
        if (burst_left == 0) begin
            gap = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid  <= 1'b1;
        s_func   <= f;
        s_id     <= idv;
        s_old_id <= oldv;
        s_count  <= cnt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = pool_predict(f, idv, oldv, cnt);
        expected_results.push_back(known ? known_res : predicted);
        if (f == FUNC_RESERVE && (predicted.status == ST_OK || predicted.status == ST_WRONG)) begin
            hr.off = int'(ID_W'(predicted.result_id - base_id));
            hr.len = cnt;
            held_runs.push_back(hr);
            if (held_runs.size() > 64)
                void'(held_runs.pop_front());
        end
    endtask

    // Hold the request channel idle until every result is back.
    task automatic drain_results();
        if (expected_results.size() != 0) begin
            s_valid <= 1'b0;
            while (expected_results.size() != 0) @(posedge aclk);
        end
    endtask

    task automatic write_lowest_id(input logic [ID_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        base_id = value;
        @(posedge aclk);
    endtask

    // Result-side stall pattern, independent of the sender.
    always @(posedge aclk) begin
        rx_tick++;
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(3));
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        case (rx_mode)
            RX_ALWAYS: m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(1));
            RX_SLOW:   m_ready <= ($urandom_range(3) == 0);
            default:   m_ready <= rx_tick[2];
        endcase
    end

    always @(posedge aclk) begin
        res_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing outstanding: id %0d count %0d status %0d",
                         $time, $signed(m_result_id), m_ref_count, m_status);
                mismatches++;
            end else begin
                exp_res = expected_results.pop_front();
                if (m_result_id !== exp_res.result_id) begin
                    $display("%0t: result_id expected %0d actual %0d", $time,
                             exp_res.result_id, $signed(m_result_id));
                    mismatches++;
                end
                if (m_ref_count !== exp_res.ref_count) begin
                    $display("%0t: ref_count expected %0d actual %0d", $time,
                             exp_res.ref_count, m_ref_count);
                    mismatches++;
                end
                if (m_status !== exp_res.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_res.status, m_status);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        res_t            got;
        logic [ID_W-1:0] idv;
        logic [ID_W-1:0] oldv;
        logic [ID_W-1:0] hot_id;
        logic [CNT_W-1:0] cnt;
        logic [ID_W-1:0] phase_base;
        int unsigned     k;
        int unsigned     j;
        for (int i = 0; i < POOL_SIZE; i++)
            usage_q[i] = ENTRY_FREE;
        bump_q  = 0;
        base_id = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_lowest_id(16'h0000);

        foreach (directed_rows[r])
            issue_request(directed_rows[r].f, directed_rows[r].id, directed_rows[r].old_id,
                          directed_rows[r].cnt, directed_rows[r].known,
                          directed_rows[r].known_res, got);

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       phase_base = 16'h8000;
                1:       phase_base = 16'h7FFF;
                2:       phase_base = ID_W'($urandom);
                3:       phase_base = 16'hFE00;
                default: phase_base = 16'h0000;
            endcase
            drain_results();
            write_lowest_id(phase_base);

            if (p == 1) begin
                // drive one entry's reference count up into saturation
                issue_request(FUNC_RESERVE, '0, '0, 11'd1, 1'b0, '0, got);
                hot_id = (got.status == ST_EXHAUSTED) ? pick_held_id() : got.result_id;
                for (int n = 0; n < HOT_ITEMS; n++) begin
                    if (n % 64 == 63) begin
                        issue_request(FUNC_QUERY, hot_id, ID_W'($urandom),
                                      CNT_W'($urandom), 1'b0, '0, got);
                    end else begin
                        k = $urandom_range(19);
                        if (k < 12)
                            oldv = base_id + ID_W'($urandom_range(65535, POOL_SIZE));
                        else if (k < 17)
                            oldv = pick_held_id();
                        else if (k == 17)
                            oldv = hot_id;
                        else
                            oldv = ID_W'($urandom);
                        issue_request(FUNC_ASSIGN, hot_id, oldv, CNT_W'($urandom),
                                      1'b0, '0, got);
                    end
                end
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(49) == 0)
                    drain_results();
                k = $urandom_range(99);
                j = $urandom_range(99);
                if (k < 30) begin
                    if (j < 70)
                        cnt = CNT_W'($urandom_range(1, 8));
                    else if (j < 88)
                        cnt = CNT_W'($urandom_range(9, 64));
                    else if (j < 96)
                        cnt = CNT_W'($urandom_range(65, 400));
                    else if (j < 98)
                        cnt = CNT_W'($urandom_range(1000, 1024));
                    else
                        cnt = CNT_W'($urandom_range(1025, 2047));
                    issue_request(FUNC_RESERVE, ID_W'($urandom), ID_W'($urandom), cnt,
                                  1'b0, '0, got);
                end else if (k < 52) begin
                    if (j < 75 && held_runs.size() != 0) begin
                        // give back a whole run that was handed out
                        j = $urandom_range(held_runs.size() - 1);
                        idv = base_id + ID_W'(held_runs[j].off);
                        cnt = CNT_W'(held_runs[j].len);
                        held_runs.delete(j);
                    end else begin
                        idv = (j % 2 == 0) ? pick_held_id() : ID_W'($urandom);
                        cnt = (j % 20 == 1) ? CNT_W'($urandom_range(2047))
                                            : CNT_W'($urandom_range(16));
                    end
                    issue_request(FUNC_UNRESERVE, idv, ID_W'($urandom), cnt, 1'b0, '0, got);
                end else if (k < 80) begin
                    if (j < 70) begin
                        idv  = pick_held_id();
                        oldv = pick_held_id();
                    end else begin
                        idv  = (j < 85) ? base_id + ID_W'($urandom_range(POOL_SIZE - 1))
                                        : ID_W'($urandom);
                        oldv = ID_W'($urandom);
                    end
                    issue_request(FUNC_ASSIGN, idv, oldv, CNT_W'($urandom), 1'b0, '0, got);
                end else begin
                    if (j < 40)
                        idv = pick_held_id();
                    else if (j < 80)
                        idv = base_id + ID_W'($urandom_range(POOL_SIZE - 1));
                    else
                        idv = ID_W'($urandom);
                    issue_request(FUNC_QUERY, idv, ID_W'($urandom), CNT_W'($urandom),
                                  1'b0, '0, got);
                end
            end
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
